>>> src/bcd_pkg.sv
// Shared types and constants for the BC1/BC2/BC3 block decoder.
`default_nettype none

package bcd_pkg;

    // Block formats as held in the format register
    localparam logic [1:0] FMT_BC1 = 2'd0;
    localparam logic [1:0] FMT_BC2 = 2'd1;

    // Reciprocals for the constant divides: q = (x * RECIP) >> SHIFT
    localparam int unsigned RECIP3_W   = 10;
    localparam logic [RECIP3_W-1:0] RECIP3 = 10'd683;
    localparam int unsigned SHIFT3     = 11;
    localparam int unsigned RECIPA_W   = 12;
    localparam logic [RECIPA_W-1:0] RECIP5 = 12'd3277;
    localparam logic [RECIPA_W-1:0] RECIP7 = 12'd2341;
    localparam int unsigned SHIFTA     = 14;

    localparam int unsigned CNUM_W = 10;
    localparam int unsigned ANUM_W = 11;

    typedef enum logic [2:0] {
        DIV_ONE     = 3'd0,
        DIV_HALF    = 3'd1,
        DIV_THIRD   = 3'd2,
        DIV_FIFTH   = 3'd3,
        DIV_SEVENTH = 3'd4
    } div_sel_t;

    // Per-texel numerators and divide selects leaving the issue stage
    typedef struct packed {
        logic [3:0]        idx;
        logic              last;
        logic [CNUM_W-1:0] r_num;
        logic [CNUM_W-1:0] g_num;
        logic [CNUM_W-1:0] b_num;
        div_sel_t          cdiv;
        logic [ANUM_W-1:0] a_num;
        div_sel_t          adiv;
    } texel_num_t;

endpackage

`default_nettype wire

>>> src/bc1_bc2_bc3_block_decoder_core.sv
// Top level of the BC1/BC2/BC3 block decoder: block buffer and texel pipeline.
//
// Input channel (in_valid / in_stall): one word is a compressed 4x4 block,
// block_low_word = bytes 0-7, block_high_word = bytes 8-15, little endian.
// Output channel (out_valid / out_stall): one word is one RGBA texel, sixteen
// per block in row-major order; last_texel marks the sixteenth.
// cfg_wr_en / cfg_wr_data write the format register (0 BC1, 1 BC2, 2 or 3 BC3);
// write it only while the block is empty.
// Throughput: one texel per cycle while out_stall does not hold it; the block
// buffer issues texels through a single 4-bit counter and takes the next block
// in the cycle its last texel is issued.
// The first texel of a block passes the block buffer, numerator, reciprocal
// product and output registers before it is on the outputs.
// When out_stall is high with a valid texel shown, the whole pipeline and the
// block buffer hold; nothing is dropped or repeated.
// Reset clears all valid bits and sets the format to BC1.
`default_nettype none

module bc1_bc2_bc3_block_decoder_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] block_low_word,
    input  wire logic [63:0] block_high_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       texel_index,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic [7:0]       alpha,
    output logic             last_texel
);

    localparam int unsigned CP_W = bcd_pkg::CNUM_W + bcd_pkg::RECIP3_W;
    localparam int unsigned AP_W = bcd_pkg::ANUM_W + bcd_pkg::RECIPA_W;

    logic [1:0]  fmt_reg;
    logic [63:0] lo_reg;
    logic [63:0] hi_reg;
    logic        blk_valid_reg;
    logic        blk_valid_next;
    logic [3:0]  cnt_reg;

    logic        adv;
    logic        issue;
    logic        in_take;

    bcd_pkg::texel_num_t issue_texel;
    bcd_pkg::texel_num_t s1_reg;
    logic                s1_valid_reg;

    bcd_pkg::texel_num_t s2_reg;
    logic                s2_valid_reg;
    logic [CP_W-1:0]     r_prod_reg;
    logic [CP_W-1:0]     g_prod_reg;
    logic [CP_W-1:0]     b_prod_reg;
    logic [AP_W-1:0]     a_prod_reg;
    logic [bcd_pkg::RECIPA_W-1:0] a_recip;

    logic [7:0] red_next;
    logic [7:0] green_next;
    logic [7:0] blue_next;
    logic [7:0] alpha_next;

    // Whole pipeline moves together unless a shown texel is held
    assign adv      = !(out_valid && out_stall);
    assign issue    = blk_valid_reg && adv;
    assign in_stall = !(adv && (!blk_valid_reg || cnt_reg == 4'd15));
    assign in_take  = in_valid && !in_stall;

    assign blk_valid_next = in_take ? 1'b1
                          : (issue && cnt_reg == 4'd15) ? 1'b0 : blk_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= bcd_pkg::FMT_BC1;
        end
        else if (cfg_wr_en)
        begin
            fmt_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid_reg <= 1'b0;
            cnt_reg       <= 4'd0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid     <= 1'b0;
        end
        else if (adv)
        begin
            blk_valid_reg <= blk_valid_next;
            if (issue)
            begin
                cnt_reg <= cnt_reg + 4'd1;   // wraps to 0 after texel 15
            end
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            out_valid    <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            lo_reg <= block_low_word;
            hi_reg <= block_high_word;
        end
    end

    bcd_texel_issue u_issue (
        .fmt   (fmt_reg),
        .lo    (lo_reg),
        .hi    (hi_reg),
        .cnt   (cnt_reg),
        .texel (issue_texel)
    );

    assign a_recip = (s1_reg.adiv == bcd_pkg::DIV_FIFTH) ? bcd_pkg::RECIP5 : bcd_pkg::RECIP7;

    // Stage 1: numerators; stage 2: reciprocal products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg     <= issue_texel;
            s2_reg     <= s1_reg;
            r_prod_reg <= CP_W'(s1_reg.r_num) * CP_W'(bcd_pkg::RECIP3);
            g_prod_reg <= CP_W'(s1_reg.g_num) * CP_W'(bcd_pkg::RECIP3);
            b_prod_reg <= CP_W'(s1_reg.b_num) * CP_W'(bcd_pkg::RECIP3);
            a_prod_reg <= AP_W'(s1_reg.a_num) * AP_W'(a_recip);
        end
    end

    always_comb
    begin
        unique case (s2_reg.cdiv)
            bcd_pkg::DIV_HALF:
            begin
                red_next   = s2_reg.r_num[8:1];
                green_next = s2_reg.g_num[8:1];
                blue_next  = s2_reg.b_num[8:1];
            end
            bcd_pkg::DIV_THIRD:
            begin
                red_next   = r_prod_reg[bcd_pkg::SHIFT3 +: 8];
                green_next = g_prod_reg[bcd_pkg::SHIFT3 +: 8];
                blue_next  = b_prod_reg[bcd_pkg::SHIFT3 +: 8];
            end
            default:
            begin
                red_next   = s2_reg.r_num[7:0];
                green_next = s2_reg.g_num[7:0];
                blue_next  = s2_reg.b_num[7:0];
            end
        endcase

        unique case (s2_reg.adiv) inside
            bcd_pkg::DIV_FIFTH,
            bcd_pkg::DIV_SEVENTH:
            begin
                alpha_next = a_prod_reg[bcd_pkg::SHIFTA +: 8];
            end
            default:
            begin
                alpha_next = s2_reg.a_num[7:0];
            end
        endcase
    end

    // Stage 3: output word
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            texel_index <= s2_reg.idx;
            last_texel  <= s2_reg.last;
            red         <= red_next;
            green       <= green_next;
            blue        <= blue_next;
            alpha       <= alpha_next;
        end
    end

endmodule

`default_nettype wire

>>> src/bcd_texel_issue.sv
// Palette and alpha ramp selection: numerators and divisors for one texel.
`default_nettype none

module bcd_texel_issue (
    input  wire logic [1:0]         fmt,
    input  wire logic [63:0]        lo,
    input  wire logic [63:0]        hi,
    input  wire logic [3:0]         cnt,
    output bcd_pkg::texel_num_t     texel
);

    function automatic logic [23:0] expand565(input logic [15:0] p);
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        r5 = p[15:11];
        g6 = p[10:5];
        b5 = p[4:0];
        return {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
    endfunction

    logic        bc1;
    logic        bc2;
    logic [63:0] cw;
    logic [15:0] c0;
    logic [15:0] c1;
    logic        punch;
    logic [1:0]  ci;
    logic [23:0] e0;
    logic [23:0] e1;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [2:0]  ai;
    logic [3:0]  nib;
    logic [2:0]  w0;
    logic [2:0]  w1;
    logic [bcd_pkg::ANUM_W-1:0] ramp_num;

    assign bc1   = (fmt == bcd_pkg::FMT_BC1);
    assign bc2   = (fmt == bcd_pkg::FMT_BC2);
    assign cw    = bc1 ? lo : hi;
    assign c0    = cw[15:0];
    assign c1    = cw[31:16];
    assign punch = bc1 && (c0 <= c1);
    assign ci    = cw[32 + 2*cnt +: 2];
    assign e0    = expand565(c0);
    assign e1    = expand565(c1);
    assign a0    = lo[7:0];
    assign a1    = lo[15:8];
    assign ai    = lo[16 + 3*cnt +: 3];
    assign nib   = lo[4*cnt +: 4];

    // BC3 ramp weights: entry k blends (8-k)/7 or (6-k)/5 of a0
    assign w0 = (a0 > a1) ? 3'(4'd8 - {1'b0, ai}) : 3'(4'd6 - {1'b0, ai});
    assign w1 = ai - 3'd1;

    assign ramp_num = bcd_pkg::ANUM_W'(w0) * bcd_pkg::ANUM_W'(a0)
                    + bcd_pkg::ANUM_W'(w1) * bcd_pkg::ANUM_W'(a1);

    always_comb
    begin
        texel.idx  = cnt;
        texel.last = (cnt == 4'd15);

        // color palette entry, per channel
        case (ci)
            2'd0:
            begin
                texel.r_num = {2'b00, e0[23:16]};
                texel.g_num = {2'b00, e0[15:8]};
                texel.b_num = {2'b00, e0[7:0]};
                texel.cdiv  = bcd_pkg::DIV_ONE;
            end
            2'd1:
            begin
                texel.r_num = {2'b00, e1[23:16]};
                texel.g_num = {2'b00, e1[15:8]};
                texel.b_num = {2'b00, e1[7:0]};
                texel.cdiv  = bcd_pkg::DIV_ONE;
            end
            2'd2:
            begin
                if (punch)
                begin
                    texel.r_num = {2'b00, e0[23:16]} + {2'b00, e1[23:16]};
                    texel.g_num = {2'b00, e0[15:8]}  + {2'b00, e1[15:8]};
                    texel.b_num = {2'b00, e0[7:0]}   + {2'b00, e1[7:0]};
                    texel.cdiv  = bcd_pkg::DIV_HALF;
                end
                else
                begin
                    texel.r_num = {1'b0, e0[23:16], 1'b0} + {2'b00, e1[23:16]};
                    texel.g_num = {1'b0, e0[15:8], 1'b0}  + {2'b00, e1[15:8]};
                    texel.b_num = {1'b0, e0[7:0], 1'b0}   + {2'b00, e1[7:0]};
                    texel.cdiv  = bcd_pkg::DIV_THIRD;
                end
            end
            default:
            begin
                if (punch)
                begin
                    texel.r_num = '0;
                    texel.g_num = '0;
                    texel.b_num = '0;
                    texel.cdiv  = bcd_pkg::DIV_ONE;
                end
                else
                begin
                    texel.r_num = {2'b00, e0[23:16]} + {1'b0, e1[23:16], 1'b0};
                    texel.g_num = {2'b00, e0[15:8]}  + {1'b0, e1[15:8], 1'b0};
                    texel.b_num = {2'b00, e0[7:0]}   + {1'b0, e1[7:0], 1'b0};
                    texel.cdiv  = bcd_pkg::DIV_THIRD;
                end
            end
        endcase

        if (bc1)
        begin
            texel.a_num = (punch && ci == 2'd3) ? '0 : bcd_pkg::ANUM_W'(255);
            texel.adiv  = bcd_pkg::DIV_ONE;
        end
        else if (bc2)
        begin
            texel.a_num = {3'b000, nib, nib};
            texel.adiv  = bcd_pkg::DIV_ONE;
        end
        else
        begin
            case (ai)
                3'd0:
                begin
                    texel.a_num = {3'b000, a0};
                    texel.adiv  = bcd_pkg::DIV_ONE;
                end
                3'd1:
                begin
                    texel.a_num = {3'b000, a1};
                    texel.adiv  = bcd_pkg::DIV_ONE;
                end
                3'd6:
                begin
                    texel.a_num = (a0 > a1) ? ramp_num : '0;
                    texel.adiv  = (a0 > a1) ? bcd_pkg::DIV_SEVENTH : bcd_pkg::DIV_ONE;
                end
                3'd7:
                begin
                    texel.a_num = (a0 > a1) ? ramp_num : bcd_pkg::ANUM_W'(255);
                    texel.adiv  = (a0 > a1) ? bcd_pkg::DIV_SEVENTH : bcd_pkg::DIV_ONE;
                end
                default:
                begin
                    texel.a_num = ramp_num;
                    texel.adiv  = (a0 > a1) ? bcd_pkg::DIV_SEVENTH : bcd_pkg::DIV_FIFTH;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> dv/tb_bc1_bc2_bc3_block_decoder_core.sv
// Self-checking testbench for the BC1/BC2/BC3 block decoder core.
`timescale 1ns / 100ps

module tb_bc1_bc2_bc3_block_decoder_core;

    localparam logic [1:0] FMT_BC3       = 2'd2;
    localparam logic [1:0] FMT_BC3_ALIAS = 2'd3;
    localparam int PHASES      = 8;
    localparam int RAND_PER    = 52;
    localparam int LAT_PAD     = 8;
    localparam int HOLD_CYC    = 400;
    localparam int WDOG_LIMIT  = 3000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } block_t;

    typedef struct packed {
        logic [3:0] idx;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic       last;
    } texel_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] block_low_word;
    logic [63:0] block_high_word;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  texel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last_texel;

    bc1_bc2_bc3_block_decoder_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .block_low_word  (block_low_word),
        .block_high_word (block_high_word),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .texel_index     (texel_index),
        .red             (red),
        .green           (green),
        .blue            (blue),
        .alpha           (alpha),
        .last_texel      (last_texel)
    );

    block_t      block_pending_q[$];
    texel_t      texel_expect_q[$];
    logic [1:0]  fmt_now;
    logic        in_taken;
    logic        calm;
    logic        rx_hold;
    int          gap_left;
    int          stall_left;
    int          blocks_queued;
    int          blocks_in;
    int          texels_out;
    int          mismatches;
    int          idle_cycles;
    int          fmt_writes;
    block_t      drv_blk;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Mostly back-to-back, sometimes a short gap, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void expand565(input logic [15:0] p,
                                      output logic [7:0] r, g, b);
        r = {p[15:11], p[15:13]};
        g = {p[10:5], p[10:9]};
        b = {p[4:0], p[4:2]};
    endfunction

    // Sixteen 3-bit alpha indices cycling 0..7
    function automatic logic [47:0] ramp_walk();
        logic [47:0] v;
        v = '0;
        for (int t = 0; t < 16; t++)
            v[3*t +: 3] = t[2:0];
        return v;
    endfunction

    function automatic block_t rand_block(input logic [1:0] fmt);
        block_t     blk;
        logic [63:0] cw;
        logic [15:0] tmp;
        blk.lo = {$urandom, $urandom};
        blk.hi = {$urandom, $urandom};
        cw = (fmt == bcd_pkg::FMT_BC1) ? blk.lo : blk.hi;
        case ($urandom_range(0, 7))
            0: cw[31:16] = cw[15:0];
            1: if (cw[15:0] > cw[31:16])
                begin
                    tmp = cw[15:0];
                    cw[15:0] = cw[31:16];
                    cw[31:16] = tmp;
                end
            2: cw[31:0] = {16'h0000, 16'hFFFF};
            3: cw[31:0] = {16'hFFFF, 16'h0000};
            default: ;
        endcase
        if (fmt == bcd_pkg::FMT_BC1)
            blk.lo = cw;
        else
            blk.hi = cw;
        case ($urandom_range(0, 5))
            0: blk.lo[15:8] = blk.lo[7:0];
            1: blk.lo[15:0] = 16'h00FF;
            2: blk.lo[15:0] = 16'hFF00;
            default: ;
        endcase
        return blk;
    endfunction

    // Expected sixteen texels of one block under format fmt
    task automatic decode_block(input logic [1:0] fmt, input block_t blk);
        logic [63:0] cw;
        logic [7:0]  pr[4];
        logic [7:0]  pg[4];
        logic [7:0]  pb[4];
        logic [7:0]  pa[4];
        int          ramp[8];
        int          a0;
        int          a1;
        logic        punch;
        logic [1:0]  ci;
        logic [3:0]  nib;
        texel_t      tx;
        cw = (fmt == bcd_pkg::FMT_BC1) ? blk.lo : blk.hi;
        expand565(cw[15:0], pr[0], pg[0], pb[0]);
        expand565(cw[31:16], pr[1], pg[1], pb[1]);
        for (int k = 0; k < 4; k++)
            pa[k] = 8'hFF;
        punch = (fmt == bcd_pkg::FMT_BC1) && (cw[15:0] <= cw[31:16]);
        if (!punch)
        begin
            pr[2] = 8'((2 * pr[0] + pr[1]) / 3);
            pg[2] = 8'((2 * pg[0] + pg[1]) / 3);
            pb[2] = 8'((2 * pb[0] + pb[1]) / 3);
            pr[3] = 8'((pr[0] + 2 * pr[1]) / 3);
            pg[3] = 8'((pg[0] + 2 * pg[1]) / 3);
            pb[3] = 8'((pb[0] + 2 * pb[1]) / 3);
        end
        else
        begin
            pr[2] = 8'((pr[0] + pr[1]) / 2);
            pg[2] = 8'((pg[0] + pg[1]) / 2);
            pb[2] = 8'((pb[0] + pb[1]) / 2);
            pr[3] = 8'h00;
            pg[3] = 8'h00;
            pb[3] = 8'h00;
            pa[3] = 8'h00;
        end
        a0 = int'(blk.lo[7:0]);
        a1 = int'(blk.lo[15:8]);
        ramp[0] = a0;
        ramp[1] = a1;
        if (a0 > a1)
        begin
            for (int i = 1; i < 7; i++)
                ramp[i + 1] = ((7 - i) * a0 + i * a1) / 7;
        end
        else
        begin
            for (int i = 1; i < 5; i++)
                ramp[i + 1] = ((5 - i) * a0 + i * a1) / 5;
            ramp[6] = 0;
            ramp[7] = 255;
        end
        for (int t = 0; t < 16; t++)
        begin
            ci = cw[32 + 2*t +: 2];
            tx.idx = t[3:0];
            tx.r = pr[ci];
            tx.g = pg[ci];
            tx.b = pb[ci];
            if (fmt == bcd_pkg::FMT_BC1)
                tx.a = pa[ci];
            else if (fmt == bcd_pkg::FMT_BC2)
            begin
                nib = blk.lo[4*t +: 4];
                tx.a = {nib, nib};
            end
            else
                tx.a = 8'(ramp[blk.lo[16 + 3*t +: 3]]);
            tx.last = (t == 15);
            texel_expect_q.push_back(tx);
        end
    endtask

    task automatic queue_block(input logic [63:0] lo, input logic [63:0] hi);
        block_t blk;
        blk.lo = lo;
        blk.hi = hi;
        block_pending_q.push_back(blk);
        blocks_queued++;
    endtask

    task automatic wait_drained();
        while (!(blocks_in == blocks_queued && texel_expect_q.size() == 0))
            @(negedge clk);
        repeat (LAT_PAD) @(negedge clk);
    endtask

    task automatic write_format(input logic [1:0] f);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= f;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        fmt_now = f;
        fmt_writes++;
    endtask

    // Input side: predict on every accepted word
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            decode_block(fmt_now, '{lo: block_low_word, hi: block_high_word});
            blocks_in++;
        end
    end

    // Output side: compare each accepted texel with the oldest expectation
    always @(posedge clk)
    begin : texel_check
        texel_t got;
        texel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            texels_out++;
            got = '{texel_index, red, green, blue, alpha, last_texel};
            if (texel_expect_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected texel idx %0d rgba %02x%02x%02x%02x last %0b",
                             got.idx, got.r, got.g, got.b, got.a, got.last);
            end
            else
            begin
                want = texel_expect_q.pop_front();
                if (got.idx !== want.idx || got.r !== want.r || got.g !== want.g ||
                    got.b !== want.b || got.a !== want.a || got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"texel mismatch: exp idx %0d rgba %02x%02x%02x%02x",
                                  " last %0b, got idx %0d rgba %02x%02x%02x%02x last %0b"},
                                 want.idx, want.r, want.g, want.b, want.a, want.last,
                                 got.idx, got.r, got.g, got.b, got.a, got.last);
                end
            end
        end
    end

    // Block driver: hold a word until it is taken, then gap or send the next
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!(in_valid && !in_taken))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (block_pending_q.size() > 0)
            begin
                drv_blk = block_pending_q.pop_front();
                block_low_word  <= drv_blk.lo;
                block_high_word <= drv_blk.hi;
                in_valid <= 1'b1;
                gap_left <= calm ? 0 : pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Texel receiver stall
    always @(negedge clk)
    begin : stall_drive
        logic s;
        s = 1'b0;
        if (stall_left > 0)
        begin
            s = 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 99) < 20)
        begin
            s = 1'b1;
            stall_left <= pick_gap();
        end
        out_stall <= rst_n && (s || rx_hold);
    end

    // Long receiver hold-off mid-run so the block backs up into in_stall
    initial
    begin
        rx_hold = 1'b0;
        wait (blocks_in >= 70);
        @(negedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYC) @(negedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("watchdog: no traffic for %0d cycles, %0d texels still due",
                     idle_cycles, texel_expect_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [1:0] phase_fmt[PHASES];
        logic [3:0] seen;
        logic [47:0] walk;
        block_t     rnd_blk;
        phase_fmt = '{bcd_pkg::FMT_BC1, bcd_pkg::FMT_BC2, FMT_BC3, FMT_BC3_ALIAS,
                      bcd_pkg::FMT_BC1, FMT_BC3, bcd_pkg::FMT_BC2, FMT_BC3_ALIAS};
        seen = '0;
        walk = ramp_walk();
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        in_taken = 1'b0;
        out_stall = 1'b0;
        block_low_word = '0;
        block_high_word = '0;
        calm = 1'b0;
        gap_left = 0;
        stall_left = 0;
        blocks_queued = 0;
        blocks_in = 0;
        texels_out = 0;
        mismatches = 0;
        idle_cycles = 0;
        fmt_writes = 0;
        fmt_now = bcd_pkg::FMT_BC1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++)
        begin
            // first phase runs on the reset format
            if (p > 0)
            begin
                wait_drained();
                write_format(phase_fmt[p]);
            end
            calm = (p == 3 || p == 6);
            @(posedge clk);
            if (!seen[phase_fmt[p]])
            begin
                seen[phase_fmt[p]] = 1'b1;
                case (phase_fmt[p])
                    bcd_pkg::FMT_BC1:
                    begin
                        // opaque four-color, punch-through c0<c1, equal endpoints
                        queue_block({32'hE4E4E4E4, 16'h0000, 16'hFFFF}, {$urandom, $urandom});
                        queue_block({32'hE4E4E4E4, 16'h07E0, 16'h001F}, '0);
                        queue_block({32'h1B1B1B1B, 16'h8410, 16'h8410}, '1);
                        queue_block('0, '0);
                        queue_block('1, '1);
                        queue_block({$urandom, 16'h07FF, 16'hF800}, {$urandom, $urandom});
                    end
                    bcd_pkg::FMT_BC2:
                    begin
                        // color with c0<=c1 must still take the four-color path
                        queue_block(64'hFEDCBA9876543210, {32'hE4E4E4E4, 16'hFFFF, 16'h0000});
                        queue_block('1, '1);
                        queue_block('0, '0);
                        queue_block({$urandom, $urandom}, {$urandom, 16'h5A5A, 16'h5A5A});
                    end
                    FMT_BC3:
                    begin
                        queue_block({walk, 8'd40, 8'd200}, {32'hE4E4E4E4, 16'h001F, 16'hF800});
                        queue_block({walk, 8'd200, 8'd40}, {32'hE4E4E4E4, 16'hFFFF, 16'h0000});
                        queue_block({walk, 8'd128, 8'd128}, {$urandom, $urandom});
                        queue_block({walk, 8'd0, 8'd255}, {$urandom, $urandom});
                        queue_block({walk, 8'd255, 8'd0}, '0);
                        queue_block('1, '1);
                    end
                    default:
                    begin
                        // spare format code decodes as BC3
                        queue_block({walk, 8'd17, 8'd230}, {32'hE4E4E4E4, 16'h07E0, 16'h001F});
                        queue_block({walk, 8'd230, 8'd17}, {$urandom, $urandom});
                    end
                endcase
            end
            for (int n = 0; n < RAND_PER; n++)
            begin
                rnd_blk = rand_block(phase_fmt[p]);
                queue_block(rnd_blk.lo, rnd_blk.hi);
            end
        end

        wait_drained();
        if (texel_expect_q.size() != 0)
            mismatches++;
        $display("Decoded %0d blocks into %0d texels over %0d format writes,",
                 blocks_in, texels_out, fmt_writes);
        $display("covering BC1 punch-through, BC2 alpha, both BC3 ramps and the spare code.");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
